// ----- hw/rtl/nfci_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the NOR flash command interface.
// No dependencies; used by nfci_decode and the top level.
package nfci_pkg;

    localparam int CMD_ADDR_BITS = 15;
    localparam int DATA_BITS     = 32;
    localparam int BYTE_BITS     = 8;
    localparam int SECT_BITS     = 13;
    localparam int SECT_LOW_BITS = 12;

    typedef logic [2:0] t_step;

    localparam t_step STEP_IDLE = 3'd0;
    localparam t_step STEP_AA1  = 3'd1;
    localparam t_step STEP_55A  = 3'd2;
    localparam t_step STEP_PROG = 3'd3;
    localparam t_step STEP_E80  = 3'd4;
    localparam t_step STEP_AA2  = 3'd5;
    localparam t_step STEP_55B  = 3'd6;

    localparam logic [CMD_ADDR_BITS-1:0] UNLOCK_ADDR1 = 15'h5555;
    localparam logic [CMD_ADDR_BITS-1:0] UNLOCK_ADDR2 = 15'h2AAA;

    localparam logic [BYTE_BITS-1:0] CMD_UNLOCK1    = 8'hAA;
    localparam logic [BYTE_BITS-1:0] CMD_UNLOCK2    = 8'h55;
    localparam logic [BYTE_BITS-1:0] CMD_ID_ENTRY   = 8'h90;
    localparam logic [BYTE_BITS-1:0] CMD_ID_EXIT    = 8'hF0;
    localparam logic [BYTE_BITS-1:0] CMD_PROGRAM    = 8'hA0;
    localparam logic [BYTE_BITS-1:0] CMD_ERASE      = 8'h80;
    localparam logic [BYTE_BITS-1:0] CMD_CHIP_ERASE = 8'h10;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_MANUF_ID     = 2'd0;
    localparam t_cfg_index CFG_DEVICE_ID    = 2'd1;
    localparam t_cfg_index CFG_SECTOR_WORDS = 2'd2;
    localparam t_cfg_index CFG_SECTOR_CMD   = 2'd3;

    typedef struct packed {
        t_step next_step;
        logic  id_mode;
        logic  chip_erase;
        logic  sect_wipe;
    } t_dec;

endpackage

// ----- hw/rtl/nor_flash_command_interface.sv -----
`timescale 1ns / 1ps
// NOR flash command interface: a 32-bit bank of byte-wide JEDEC parts.
// A request (i_mode, i_word_addr, i_wdata) is taken when start is high and
// busy is low. Each request gives exactly one result on o_rdata/o_id_active,
// marked by o_valid for one cycle; the receiver cannot hold it off.
// Reads, programs and plain command writes: the store is read at the accept
// edge and the result (or the program write-back) is registered in the next
// cycle; busy stays high until then, so a new request waits for the last.
// Chip erase walks the whole store, one word a cycle, all 2**WORD_ADDR_BITS
// words; sector erase walks 1024, 2048 or 4096 words likewise. The result
// of an erase request appears when the walk ends; busy stays high meanwhile.
// After reset the store is cleared to all ones by the same walk over every
// word, with busy high; configuration writes are taken
// at any time through i_cfg_valid/o_cfg_ready (ready is always high) and are
// meant to be issued only while no request is outstanding.
// Depends on nfci_pkg, nfci_decode and nfci_store.
module nor_flash_command_interface #(
    parameter int WORD_ADDR_BITS = 17
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_mode,
    input  logic [WORD_ADDR_BITS-1:0]            i_word_addr,
    input  logic [31:0]                          i_wdata,
    output logic                                 o_valid,
    output logic [31:0]                          o_rdata,
    output logic                                 o_id_active,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  nfci_pkg::t_cfg_index                 i_cfg_index,
    input  logic [nfci_pkg::SECT_BITS-1:0]       i_cfg_data
);
    import nfci_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_SECT  = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [WORD_ADDR_BITS-1:0] r_cnt, n_cnt;
    logic                      r_owe, n_owe;
    logic                      r_mode, n_mode;
    logic [WORD_ADDR_BITS-1:0] r_addr, n_addr;
    logic [31:0]               r_wdata, n_wdata;
    t_step                     r_step, n_step;
    logic                      r_id, n_id;
    logic                      r_valid, n_valid;
    logic [31:0]               r_rdata, n_rdata;
    logic                      r_id_out, n_id_out;

    logic [BYTE_BITS-1:0]      r_manuf_id;
    logic [BYTE_BITS-1:0]      r_device_id;
    logic [SECT_BITS-1:0]      r_sector_words;
    logic [BYTE_BITS-1:0]      r_sector_cmd;

    logic                      mem_we;
    logic [WORD_ADDR_BITS-1:0] mem_waddr;
    logic [31:0]               mem_wdata;
    logic [31:0]               mem_rdata;

    t_dec                      dec;
    logic [SECT_LOW_BITS-1:0]  sect_mask;
    logic [WORD_ADDR_BITS-1:0] sect_base;
    logic                      sect_end;

    nfci_store #(
        .ADDR_BITS (WORD_ADDR_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (i_word_addr),
        .o_rdata (mem_rdata)
    );

    nfci_decode u_decode (
        .i_step       (r_step),
        .i_cmd_addr   (r_addr[CMD_ADDR_BITS-1:0]),
        .i_cmd        (r_wdata[BYTE_BITS-1:0]),
        .i_sector_cmd (r_sector_cmd),
        .i_id_mode    (r_id),
        .o_dec        (dec)
    );

    // Sector size is clamped to 1024..4096 words and rounded down to a power of two.
    always_comb begin
        if (r_sector_words[12]) begin
            sect_mask = 12'hFFF;
        end else if (r_sector_words[11]) begin
            sect_mask = 12'h7FF;
        end else begin
            sect_mask = 12'h3FF;
        end
    end

    assign sect_base = r_addr & ~WORD_ADDR_BITS'(sect_mask);
    assign sect_end  = ((r_cnt[SECT_LOW_BITS-1:0] & sect_mask) == sect_mask);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_owe     = r_owe;
        n_mode    = r_mode;
        n_addr    = r_addr;
        n_wdata   = r_wdata;
        n_step    = r_step;
        n_id      = r_id;
        n_valid   = 1'b0;
        n_rdata   = r_rdata;
        n_id_out  = r_id_out;
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = '1;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_IDLE;
                    n_owe   = 1'b0;
                    if (r_owe) begin
                        n_valid  = 1'b1;
                        n_rdata  = '0;
                        n_id_out = r_id;
                    end
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_mode  = i_mode;
                    n_addr  = i_word_addr;
                    n_wdata = i_wdata;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_mode) begin
                    n_valid  = 1'b1;
                    n_id_out = r_id;
                    n_state  = S_IDLE;
                    if (r_id && r_addr == WORD_ADDR_BITS'(0)) begin
                        n_rdata = {4{r_manuf_id}};
                    end else if (r_id && r_addr == WORD_ADDR_BITS'(1)) begin
                        n_rdata = {4{r_device_id}};
                    end else begin
                        n_rdata = mem_rdata;
                    end
                end else if (r_step == STEP_PROG) begin
                    // Programming can only clear bits.
                    mem_we    = 1'b1;
                    mem_waddr = r_addr;
                    mem_wdata = mem_rdata & r_wdata;
                    n_step    = STEP_IDLE;
                    n_valid   = 1'b1;
                    n_rdata   = '0;
                    n_id_out  = r_id;
                    n_state   = S_IDLE;
                end else begin
                    n_step = dec.next_step;
                    n_id   = dec.id_mode;
                    if (dec.chip_erase) begin
                        n_state = S_CLEAR;
                        n_cnt   = '0;
                        n_owe   = 1'b1;
                    end else if (dec.sect_wipe) begin
                        n_state = S_SECT;
                        n_cnt   = sect_base;
                    end else begin
                        n_valid  = 1'b1;
                        n_rdata  = '0;
                        n_id_out = dec.id_mode;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_SECT: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (sect_end) begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_rdata  = '0;
                    n_id_out = r_id;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_owe   <= 1'b0;
            r_step  <= STEP_IDLE;
            r_id    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_owe   <= n_owe;
            r_step  <= n_step;
            r_id    <= n_id;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_addr   <= n_addr;
        r_wdata  <= n_wdata;
        r_rdata  <= n_rdata;
        r_id_out <= n_id_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manuf_id     <= 8'hBF;
            r_device_id    <= 8'hB5;
            r_sector_words <= 13'd4096;
            r_sector_cmd   <= 8'h30;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MANUF_ID:     r_manuf_id     <= i_cfg_data[BYTE_BITS-1:0];
                CFG_DEVICE_ID:    r_device_id    <= i_cfg_data[BYTE_BITS-1:0];
                CFG_SECTOR_WORDS: r_sector_words <= i_cfg_data;
                CFG_SECTOR_CMD:   r_sector_cmd   <= i_cfg_data[BYTE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_rdata     = r_rdata;
    assign o_id_active = r_id_out;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result issued while still busy");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_mode) |-> (r_rdata == '0))
        else $error("write request returned non-zero data");

    a_sect_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SECT) |=> (r_state == S_SECT || r_state == S_IDLE))
        else $error("sector erase walk left to an unexpected state");

endmodule

// ----- hw/rtl/nfci_store.sv -----
`timescale 1ns / 1ps
// Flash word store: one write port and one read port with registered data.
// Standalone; no package needed.
module nfci_store #(
    parameter int ADDR_BITS = 17
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [31:0]          i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [31:0]          o_rdata
);

    logic [31:0] r_mem [2**ADDR_BITS];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/nfci_decode.sv -----
`timescale 1ns / 1ps
// JEDEC command sequence decoder for one bus write request.
// Depends on nfci_pkg for step codes, command bytes and the result struct.
module nfci_decode (
    input  nfci_pkg::t_step                          i_step,
    input  logic [nfci_pkg::CMD_ADDR_BITS-1:0]       i_cmd_addr,
    input  logic [nfci_pkg::BYTE_BITS-1:0]           i_cmd,
    input  logic [nfci_pkg::BYTE_BITS-1:0]           i_sector_cmd,
    input  logic                                     i_id_mode,
    output nfci_pkg::t_dec                           o_dec
);
    import nfci_pkg::*;

    logic at1;
    logic at2;

    assign at1 = (i_cmd_addr == UNLOCK_ADDR1);
    assign at2 = (i_cmd_addr == UNLOCK_ADDR2);

    always_comb begin
        o_dec.next_step    = STEP_IDLE;
        o_dec.id_mode      = i_id_mode;
        o_dec.chip_erase   = 1'b0;
        o_dec.sect_wipe    = 1'b0;
        case (i_step)
            STEP_AA1: begin
                if (at2 && i_cmd == CMD_UNLOCK2) o_dec.next_step = STEP_55A;
            end
            STEP_55A: begin
                if (at1 && i_cmd == CMD_ID_ENTRY) begin
                    o_dec.id_mode = 1'b1;
                end else if (at1 && i_cmd == CMD_PROGRAM) begin
                    o_dec.next_step = STEP_PROG;
                end else if (at1 && i_cmd == CMD_ERASE) begin
                    o_dec.next_step = STEP_E80;
                end
            end
            STEP_E80: begin
                if (at1 && i_cmd == CMD_UNLOCK1) o_dec.next_step = STEP_AA2;
            end
            STEP_AA2: begin
                if (at2 && i_cmd == CMD_UNLOCK2) o_dec.next_step = STEP_55B;
            end
            STEP_55B: begin
                // Chip erase takes precedence if the sector command clashes with it.
                if (at1 && i_cmd == CMD_CHIP_ERASE) begin
                    o_dec.chip_erase = 1'b1;
                end else if (i_cmd == i_sector_cmd) begin
                    o_dec.sect_wipe = 1'b1;
                end
            end
            default: begin
                if (at1 && i_cmd == CMD_UNLOCK1) o_dec.next_step = STEP_AA1;
            end
        endcase
        // A stray exit command always leaves ID mode and resets the sequence.
        if (i_cmd == CMD_ID_EXIT) begin
            o_dec.id_mode   = 1'b0;
            o_dec.next_step = STEP_IDLE;
        end
    end

endmodule

// ----- verif/nor_flash_command_interface_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for nor_flash_command_interface: directed and random
// JEDEC command traffic is checked, result by result, against a mirror of
// the flash bank kept here. Depends on nfci_pkg and the RTL of the block.
module nor_flash_command_interface_tb;
    import nfci_pkg::*;

    localparam int ADDR_W = 17;
    localparam int BANK_WORDS = 1 << ADDR_W;
    localparam int CLK_HALF = 10;
    localparam longint RUN_LIMIT_NS = 64'd100_000_000;
    localparam int PHASE_ITEMS = 475;
    localparam int MAX_REPORTS = 10;
    localparam int BREAK_PCT = 12;

    localparam bit ACC_READ = 1'b0;
    localparam bit ACC_WRITE = 1'b1;
    localparam logic [BYTE_BITS-1:0] SECT_CMD_STD = 8'h30;
    localparam logic [BYTE_BITS-1:0] SECT_CMD_ALT = 8'h50;
    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] rdata;
        logic        id_active;
    } t_reply;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
    } t_write;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
        logic              typed;
        logic [31:0]       exp_rdata;
        logic              exp_id;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_mode = 1'b0;
    logic [ADDR_W-1:0]    i_word_addr = '0;
    logic [31:0]          i_wdata = '0;
    logic                 o_valid;
    logic [31:0]          o_rdata;
    logic                 o_id_active;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_index           i_cfg_index = CFG_MANUF_ID;
    logic [SECT_BITS-1:0] i_cfg_data = '0;

    // Mirror of the bank, the command decoder and the registers.
    logic [31:0]          bank_image [0:BANK_WORDS-1];
    t_step                cmd_step;
    logic                 in_id_mode;
    logic [7:0]           manuf_byte;
    logic [7:0]           device_byte;
    logic [7:0]           sect_cmd_byte;
    logic [SECT_BITS-1:0] sect_words_reg;

    t_reply            replies_due [$];
    t_write            cmd_seq [$];
    logic [ADDR_W-1:0] touched_addrs [$];
    int                faults = 0;
    int                accesses_issued = 0;
    int                sender_idle_pct = 0;
    int                chip_erases_left = 2;

    // Every row is a request; typed rows carry a reply that is plain from the spec.
    t_row directed_rows [25] = '{
        '{ACC_READ,  17'h00000, 32'h0000_0000, 1'b1, ERASED_WORD,   1'b0},
        '{ACC_READ,  17'h1FFFF, 32'h0000_0000, 1'b1, ERASED_WORD,   1'b0},
        '{ACC_WRITE, 17'h05555, 32'h0000_00AA, 1'b1, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h02AAA, 32'h0000_0055, 1'b1, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h05555, 32'h0000_0090, 1'b1, 32'h0,         1'b1},
        '{ACC_READ,  17'h00000, 32'h0000_0000, 1'b1, 32'hBFBF_BFBF, 1'b1},
        '{ACC_READ,  17'h00001, 32'h0000_0000, 1'b1, 32'hB5B5_B5B5, 1'b1},
        '{ACC_READ,  17'h10000, 32'h0000_0000, 1'b1, ERASED_WORD,   1'b1},
        '{ACC_WRITE, 17'h1D555, 32'h1234_56AA, 1'b1, 32'h0,         1'b1},
        '{ACC_WRITE, 17'h0AAAA, 32'h8765_4355, 1'b1, 32'h0,         1'b1},
        '{ACC_WRITE, 17'h05555, 32'h0000_00A0, 1'b1, 32'h0,         1'b1},
        '{ACC_WRITE, 17'h00000, 32'hF0F0_F0F0, 1'b1, 32'h0,         1'b1},
        '{ACC_READ,  17'h00000, 32'h0000_0000, 1'b1, 32'hBFBF_BFBF, 1'b1},
        '{ACC_WRITE, 17'h12345, 32'hABCD_EFF0, 1'b1, 32'h0,         1'b0},
        '{ACC_READ,  17'h00000, 32'h0000_0000, 1'b1, 32'hF0F0_F0F0, 1'b0},
        '{ACC_WRITE, 17'h05555, 32'h0000_00AA, 1'b0, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h05555, 32'h0000_0055, 1'b0, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h05555, 32'h0000_00AA, 1'b0, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h02AAA, 32'h0000_0055, 1'b0, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h05555, 32'h0000_0080, 1'b0, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h05555, 32'h0000_00AA, 1'b0, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h02AAA, 32'h0000_0055, 1'b0, 32'h0,         1'b0},
        '{ACC_WRITE, 17'h00123, 32'h0000_0030, 1'b1, 32'h0,         1'b0},
        '{ACC_READ,  17'h00000, 32'h0000_0000, 1'b1, ERASED_WORD,   1'b0},
        '{ACC_WRITE, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0}
    };

    nor_flash_command_interface #(
        .WORD_ADDR_BITS(ADDR_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_word_addr (i_word_addr),
        .i_wdata     (i_wdata),
        .o_valid     (o_valid),
        .o_rdata     (o_rdata),
        .o_id_active (o_id_active),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void note_fault(string what);
        faults++;
        if (faults <= MAX_REPORTS) begin
            $display("[%0t] %s", $time, what);
        end
    endfunction

    // Out-of-range sector sizes are clamped, the rest rounded down to a power of two.
    function automatic int unsigned sector_span();
        int unsigned span;
        span = 4096;
        if (sect_words_reg < 1024) return 1024;
        if (sect_words_reg > 4096) return 4096;
        while (span > sect_words_reg) span = span >> 1;
        return span;
    endfunction

    function automatic void wipe_words(int unsigned first, int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            bank_image[first + i] = ERASED_WORD;
        end
    endfunction

    function automatic t_reply decode_access(logic is_write, logic [ADDR_W-1:0] addr,
                                             logic [31:0] data);
        t_reply           reply;
        t_step            next_step;
        logic [7:0]       code;
        logic             at_first;
        logic             at_second;
        int unsigned      span;
        reply = '0;
        next_step = STEP_IDLE;
        code = data[7:0];
        at_first = addr[CMD_ADDR_BITS-1:0] == UNLOCK_ADDR1;
        at_second = addr[CMD_ADDR_BITS-1:0] == UNLOCK_ADDR2;
        if (!is_write) begin
            if (in_id_mode && addr == '0) begin
                reply.rdata = {4{manuf_byte}};
            end else if (in_id_mode && addr == ADDR_W'(1)) begin
                reply.rdata = {4{device_byte}};
            end else begin
                reply.rdata = bank_image[addr];
            end
        end else if (cmd_step == STEP_PROG) begin
            // An armed program takes any data, an F0 byte included.
            bank_image[addr] &= data;
        end else begin
            case (cmd_step)
                STEP_AA1: if (at_second && code == CMD_UNLOCK2) next_step = STEP_55A;
                STEP_55A: begin
                    if (at_first && code == CMD_ID_ENTRY) in_id_mode = 1'b1;
                    else if (at_first && code == CMD_PROGRAM) next_step = STEP_PROG;
                    else if (at_first && code == CMD_ERASE) next_step = STEP_E80;
                end
                STEP_E80: if (at_first && code == CMD_UNLOCK1) next_step = STEP_AA2;
                STEP_AA2: if (at_second && code == CMD_UNLOCK2) next_step = STEP_55B;
                STEP_55B: begin
                    // Chip erase takes precedence when the sector command is also 10.
                    if (at_first && code == CMD_CHIP_ERASE) begin
                        wipe_words(0, BANK_WORDS);
                    end else if (code == sect_cmd_byte) begin
                        span = sector_span();
                        wipe_words(int'(addr) & ~(int'(span) - 1), span);
                    end
                end
                // Idle and the unused step value behave alike.
                default: if (at_first && code == CMD_UNLOCK1) next_step = STEP_AA1;
            endcase
            if (code == CMD_ID_EXIT) begin
                in_id_mode = 1'b0;
                next_step = STEP_IDLE;
            end
        end
        if (is_write) cmd_step = next_step;
        reply.id_active = in_id_mode;
        return reply;
    endfunction

    task automatic bus_access(logic is_write, logic [ADDR_W-1:0] addr, logic [31:0] data,
                              logic typed, t_reply typed_reply);
        t_reply predicted;
        start <= 1'b1;
        i_mode <= is_write;
        i_word_addr <= addr;
        i_wdata <= data;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = decode_access(is_write, addr, data);
        replies_due.push_back(typed ? typed_reply : predicted);
        accesses_issued++;
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic write_word(logic [ADDR_W-1:0] addr, logic [31:0] data);
        bus_access(ACC_WRITE, addr, data, 1'b0, '0);
    endtask

    task automatic read_word(logic [ADDR_W-1:0] addr);
        bus_access(ACC_READ, addr, 32'h0, 1'b0, '0);
    endtask

    // Waits until every outstanding request has been answered and the block is idle.
    task automatic quiesce();
        start <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, logic [SECT_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_MANUF_ID:     manuf_byte = value[7:0];
            CFG_DEVICE_ID:    device_byte = value[7:0];
            CFG_SECTOR_WORDS: sect_words_reg = value;
            CFG_SECTOR_CMD:   sect_cmd_byte = value[7:0];
            default: ;
        endcase
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35 && touched_addrs.size() > 0) begin
            return touched_addrs[$urandom_range(touched_addrs.size() - 1)];
        end
        if (roll < 50) return ADDR_W'($urandom_range(1));
        if (roll < 55) return '1;
        return ADDR_W'($urandom);
    endfunction

    // Command write with random upper address and data bits.
    task automatic push_command(logic [CMD_ADDR_BITS-1:0] where, logic [7:0] code);
        t_write w;
        w.addr = ADDR_W'($urandom);
        w.addr[CMD_ADDR_BITS-1:0] = where;
        w.data = $urandom;
        w.data[7:0] = code;
        cmd_seq.push_back(w);
    endtask

    task automatic push_unlock();
        push_command(UNLOCK_ADDR1, CMD_UNLOCK1);
        push_command(UNLOCK_ADDR2, CMD_UNLOCK2);
    endtask

    task automatic push_erase_prefix();
        push_unlock();
        push_command(UNLOCK_ADDR1, CMD_ERASE);
        push_unlock();
    endtask

    // Sends the queued writes; now and then one is spoilt or the tail dropped.
    task automatic run_sequence(int break_pct);
        int     cut;
        int     flaw;
        t_write w;
        cut = -1;
        flaw = $urandom_range(2);
        if ($urandom_range(99) < break_pct) cut = $urandom_range(cmd_seq.size() - 1);
        foreach (cmd_seq[i]) begin
            w = cmd_seq[i];
            if (i == cut) begin
                if (flaw == 0) break;
                if (flaw == 1) w.addr = ADDR_W'($urandom);
                else w.data[7:0] = 8'($urandom);
            end
            write_word(w.addr, w.data);
        end
        cmd_seq.delete();
    endtask

    task automatic erase_chip();
        push_erase_prefix();
        push_command(UNLOCK_ADDR1, CMD_CHIP_ERASE);
        run_sequence(0);
        read_word(pick_addr());
    endtask

    task automatic run_burst();
        int                pick;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        addr = pick_addr();
        if (pick < 18) begin
            repeat ($urandom_range(3, 1)) read_word(pick_addr());
        end else if (pick < 28) begin
            push_unlock();
            push_command(UNLOCK_ADDR1, CMD_ID_ENTRY);
            run_sequence(BREAK_PCT);
        end else if (pick < 33) begin
            push_unlock();
            push_command(UNLOCK_ADDR1, CMD_ID_EXIT);
            run_sequence(BREAK_PCT);
        end else if (pick < 38) begin
            push_command(CMD_ADDR_BITS'($urandom), CMD_ID_EXIT);
            run_sequence(0);
        end else if (pick < 63) begin
            push_unlock();
            push_command(UNLOCK_ADDR1, CMD_PROGRAM);
            cmd_seq.push_back({addr, 32'($urandom | $urandom)});
            run_sequence(BREAK_PCT);
            touched_addrs.push_back(addr);
            if (touched_addrs.size() > 40) void'(touched_addrs.pop_front());
            if ($urandom_range(1)) read_word(addr);
        end else if (pick == 70 && chip_erases_left > 0) begin
            chip_erases_left--;
            erase_chip();
        end else if (pick < 71) begin
            push_erase_prefix();
            cmd_seq.push_back({addr, 24'($urandom), sect_cmd_byte});
            run_sequence(BREAK_PCT);
            read_word(addr);
        end else if (pick < 85) begin
            if ($urandom_range(1)) write_word(ADDR_W'($urandom), 32'($urandom));
            else read_word(ADDR_W'($urandom));
        end else begin
            // A valid prefix cut short by an unrelated write.
            push_erase_prefix();
            while (cmd_seq.size() > $urandom_range(5, 1)) void'(cmd_seq.pop_back());
            cmd_seq.push_back({ADDR_W'($urandom), 32'($urandom)});
            run_sequence(0);
        end
    endtask

    task automatic run_phase(int idle_pct, logic [SECT_BITS-1:0] manuf,
                             logic [SECT_BITS-1:0] device, logic [SECT_BITS-1:0] words,
                             logic [SECT_BITS-1:0] sect_cmd, bit with_chip_erase);
        int stop_at;
        quiesce();
        write_register(CFG_MANUF_ID, manuf);
        write_register(CFG_DEVICE_ID, device);
        write_register(CFG_SECTOR_WORDS, words);
        write_register(CFG_SECTOR_CMD, sect_cmd);
        i_cfg_valid <= 1'b0;
        sender_idle_pct = idle_pct;
        if (with_chip_erase) erase_chip();
        stop_at = accesses_issued + PHASE_ITEMS;
        while (accesses_issued < stop_at) run_burst();
    endtask

    always @(posedge i_clk) begin : result_check
        t_reply due;
        if (i_rst_n && o_valid === 1'b1) begin
            if (replies_due.size() == 0) begin
                note_fault($sformatf("result with no request outstanding: rdata %08h id %0b",
                                     o_rdata, o_id_active));
            end else begin
                due = replies_due.pop_front();
                if (o_rdata !== due.rdata) begin
                    note_fault($sformatf("rdata differs: expected %08h, got %08h",
                                         due.rdata, o_rdata));
                end
                if (o_id_active !== due.id_active) begin
                    note_fault($sformatf("id_active differs: expected %0b, got %0b",
                                         due.id_active, o_id_active));
                end
            end
        end
    end

    initial begin
        wipe_words(0, BANK_WORDS);
        cmd_step = STEP_IDLE;
        in_id_mode = 1'b0;
        manuf_byte = 8'hBF;
        device_byte = 8'hB5;
        sect_words_reg = 13'd4096;
        sect_cmd_byte = SECT_CMD_STD;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The clearing pass after reset is absorbed by the wait on busy.
        foreach (directed_rows[r]) begin
            bus_access(directed_rows[r].mode, directed_rows[r].addr, directed_rows[r].data,
                       directed_rows[r].typed,
                       {directed_rows[r].exp_rdata, directed_rows[r].exp_id});
        end

        run_phase(13, SECT_BITS'($urandom), SECT_BITS'($urandom), 13'd0,
                  {5'b0, SECT_CMD_ALT}, 1'b0);
        run_phase(71, 13'h1F00, 13'h1FFF, 13'h1FFF, {5'h1F, SECT_CMD_STD}, 1'b0);
        run_phase(0, 13'h00FF, 13'h0000, 13'd3000, {5'b0, CMD_CHIP_ERASE}, 1'b1);
        run_phase(0, SECT_BITS'($urandom), SECT_BITS'($urandom), 13'd1024, 13'h00FF, 1'b0);
        quiesce();

        if (faults == 0 && replies_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
